/* hw/rtl/hlbcd_pkg.sv */
`timescale 1ns / 1ps

package hlbcd_pkg;

	// Cache geometry.
	localparam int NUM_BUCKETS = 13;
	localparam int WAYS        = 4;
	localparam int TOTAL_SLOTS = NUM_BUCKETS * WAYS;

	// Transaction field widths.
	localparam int OP_W     = 2;
	localparam int DEV_W    = 8;
	localparam int BLK_W    = 32;
	localparam int SLOT_W   = 6;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = 8;

	// Derived widths.
	localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_W = WAY_W;
	localparam int ADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
	localparam int WCNT_W = $clog2(WAYS + 1);
	localparam int NIB_N  = BLK_W / 4;
	localparam int NIBC_W = $clog2(NIB_N);

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [OP_W-1:0] {
		OP_GET     = 2'd0,
		OP_RELEASE = 2'd1,
		OP_PIN     = 2'd2,
		OP_UNPIN   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_NOFREE = 2'd1,
		STAT_UNDER  = 2'd2,
		STAT_OVER   = 2'd3
	} status_t;

	// One directory entry as kept in the entry memory.
	typedef struct packed {
		logic [DEV_W-1:0]  dev;
		logic [BLK_W-1:0]  blk;
		logic              cval;
		logic [CNT_W-1:0]  cnt;
		logic [RANK_W-1:0] rank;
	} rec_t;

	// Result fields waiting for the output register.
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              hit;
		logic              needs_read;
		status_t           status;
	} res_t;

endpackage

/* hw/rtl/hlbcd_req_if.sv */
`timescale 1ns / 1ps

interface hlbcd_req_if;
	import hlbcd_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [DEV_W-1:0]  device;
	logic [BLK_W-1:0]  block_number;
	logic [SLOT_W-1:0] slot;

	modport source (output valid, output op, output device, output block_number,
		output slot, input ready);
	modport sink (input valid, input op, input device, input block_number,
		input slot, output ready);
endinterface

/* hw/rtl/hlbcd_rsp_if.sv */
`timescale 1ns / 1ps

interface hlbcd_rsp_if;
	import hlbcd_pkg::*;

	logic                valid;
	logic                ready;
	logic [SLOT_W-1:0]   result_slot;
	logic                hit;
	logic                needs_read;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output result_slot, output hit, output needs_read,
		output status, input ready);
	modport sink (input valid, input result_slot, input hit, input needs_read,
		input status, output ready);
endinterface

/* hw/rtl/hashed_lru_block_cache_directory.sv */
`timescale 1ns / 1ps

// Channel | Direction | Payload                                   | Handshake
// req     | in        | op, device, block_number, slot            | valid / ready
// rsp     | out       | result_slot, hit, needs_read, status      | valid / ready
//
// A get reduces the bucket index modulo NUM_BUCKETS one nibble per cycle, then reads the
// ways one per cycle from the single read port of the entry memory. Release, pin and unpin
// read and update the addressed slot (a slot past the last buffer is only echoed); a release
// that drops the count to zero then sweeps the bucket. Reset needs no clearing pass: a valid
// bit per entry makes untouched entries read as their reset value. A new transaction is
// accepted while a result waits in the output register; a stalled rsp only holds the block
// once the next result is ready.

module hashed_lru_block_cache_directory (
	input logic            clk,
	input logic            arst_n,
	hlbcd_req_if.sink      req,
	hlbcd_rsp_if.source    rsp
);
	import hlbcd_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_HASH     = 7'b0000010,
		ST_SCAN     = 7'b0000100,
		ST_GET_WR   = 7'b0001000,
		ST_SLOT_UPD = 7'b0010000,
		ST_SWEEP    = 7'b0100000,
		ST_DONE     = 7'b1000000
	} state_t;

	// One step of the remainder: r' = (16 * r + nib) mod NUM_BUCKETS. The value stays
	// below 16 * NUM_BUCKETS, so the largest fitting multiple is found by parallel
	// compares.
	function automatic logic [BKT_W-1:0] mod_step(input logic [BKT_W-1:0] r,
		input logic [3:0] nib);
		logic [BKT_W+3:0] v;
		logic [BKT_W+3:0] res;
		v = {r, 4'b0000} + (BKT_W+4)'(nib);
		res = v;
		for (int k = 1; k < 16; k++) begin
			if (v >= (BKT_W+4)'(k * NUM_BUCKETS))
				res = v - (BKT_W+4)'(k * NUM_BUCKETS);
		end
		return BKT_W'(res);
	endfunction

	// Bucket of an in-range slot.
	function automatic logic [BKT_W-1:0] slot_bkt(input logic [SLOT_W-1:0] s);
		logic [BKT_W-1:0] b;
		b = '0;
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			if (int'(s) >= i * WAYS)
				b = BKT_W'(i);
		end
		return b;
	endfunction

	// Way of an in-range slot within its bucket.
	function automatic logic [WAY_W-1:0] slot_way(input logic [SLOT_W-1:0] s);
		logic [WAY_W-1:0] w;
		w = '0;
		for (int i = 0; i < NUM_BUCKETS; i++) begin
			if (int'(s) >= i * WAYS)
				w = WAY_W'(int'(s) - i * WAYS);
		end
		return w;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [BKT_W-1:0] b,
		input logic [WAY_W-1:0] w);
		return ADDR_W'(int'(b) * WAYS + int'(w));
	endfunction

	// Control state.
	state_t               state_q;
	logic [NIBC_W-1:0]    nib_cnt_q;
	logic [WCNT_W-1:0]    rd_cnt_q;
	logic                 rd_vld_s1;
	logic                 hit_found_q;
	logic                 free_found_q;
	logic                 rsp_valid_q;
	logic [TOTAL_SLOTS-1:0] ent_valid_q;

	// Transaction and scan payload.
	op_t                  op_q;
	logic [DEV_W-1:0]     dev_q;
	logic [BLK_W-1:0]     blk_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [BKT_W-1:0]     bkt_q;
	logic [WAY_W-1:0]     way_q;
	logic [WAY_W-1:0]     hit_way_q;
	logic [RANK_W-1:0]    hit_rank_q;
	logic [CNT_W-1:0]     hit_cnt_q;
	logic                 hit_cval_q;
	logic [WAY_W-1:0]     free_way_q;
	logic [RANK_W-1:0]    free_rank_q;
	logic [RANK_W-1:0]    old_rank_q;
	res_t                 res_q;
	res_t                 rsp_q;

	// Entry memory with one read and one write port.
	rec_t                 mem [TOTAL_SLOTS];
	rec_t                 mem_rd_s1;
	logic                 rd_ev_s1;
	logic [WAY_W-1:0]     rd_way_s1;
	rec_t                 rd_rec;

	logic                 rd_en;
	logic [ADDR_W-1:0]    rd_addr;
	logic [WAY_W-1:0]     rd_way;
	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	rec_t                 wr_rec;

	logic                 req_acc;
	logic                 rsp_load;
	logic                 slot_in_range;
	logic                 rec_match;
	logic                 scan_last;
	logic [NIBC_W-1:0]    nib_idx;
	logic [3:0]           nib;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc = req.valid && (state_q == ST_IDLE);
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);
	assign slot_in_range = (int'(req.slot) < TOTAL_SLOTS);

	assign nib_idx = NIBC_W'(NIB_N - 1) - nib_cnt_q;
	assign nib = blk_q[{nib_idx, 2'b00} +: 4];

	// An entry never written since reset reads as its reset value: all zero, with
	// the rank equal to the way index.
	always_comb begin
		if (rd_ev_s1) begin
			rd_rec = mem_rd_s1;
		end else begin
			rd_rec = '0;
			rd_rec.rank = RANK_W'(rd_way_s1);
		end
	end

	assign rec_match = (rd_rec.dev == dev_q) && (rd_rec.blk == blk_q);
	assign scan_last = rd_vld_s1 && (rd_way_s1 == WAY_W'(WAYS - 1));

	// Read port requests.
	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		rd_way = '0;
		if (req_acc && (op_t'(req.op) != OP_GET) && slot_in_range) begin
			rd_en = 1'b1;
			rd_addr = ADDR_W'(req.slot);
			rd_way = slot_way(req.slot);
		end else if (((state_q == ST_SCAN) || (state_q == ST_SWEEP)) &&
			(rd_cnt_q < WCNT_W'(WAYS))) begin
			rd_en = 1'b1;
			rd_way = WAY_W'(rd_cnt_q);
			rd_addr = slot_addr(bkt_q, rd_way);
		end
	end

	// Write port requests.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = '0;
		wr_rec = rd_rec;
		unique case (state_q)
			ST_GET_WR: begin
				if (hit_found_q) begin
					wr_en = (hit_cnt_q != COUNT_MAX);
					wr_addr = slot_addr(bkt_q, hit_way_q);
					wr_rec.dev = dev_q;
					wr_rec.blk = blk_q;
					wr_rec.cval = 1'b1;
					wr_rec.cnt = hit_cnt_q + CNT_W'(1);
					wr_rec.rank = hit_rank_q;
				end else begin
					wr_en = free_found_q;
					wr_addr = slot_addr(bkt_q, free_way_q);
					wr_rec.dev = dev_q;
					wr_rec.blk = blk_q;
					wr_rec.cval = 1'b1;
					wr_rec.cnt = CNT_W'(1);
					wr_rec.rank = free_rank_q;
				end
			end
			ST_SLOT_UPD: begin
				wr_addr = ADDR_W'(slot_q);
				if (op_q == OP_PIN) begin
					wr_en = (rd_rec.cnt != COUNT_MAX);
					wr_rec.cnt = rd_rec.cnt + CNT_W'(1);
				end else begin
					wr_en = (rd_rec.cnt != '0);
					wr_rec.cnt = rd_rec.cnt - CNT_W'(1);
					if ((op_q == OP_RELEASE) && (rd_rec.cnt == CNT_W'(1)))
						wr_rec.rank = RANK_W'(WAYS - 1);
				end
			end
			ST_SWEEP: begin
				// Every other way that ranked above the released one moves down.
				wr_en = rd_vld_s1 && (rd_way_s1 != way_q) && (rd_rec.rank > old_rank_q);
				wr_addr = slot_addr(bkt_q, rd_way_s1);
				wr_rec.rank = rd_rec.rank - RANK_W'(1);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Entry memory.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_rec;
		if (rd_en)
			mem_rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_ev_s1 <= ent_valid_q[rd_addr];
			rd_way_s1 <= rd_way;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (wr_en)
				ent_valid_q[wr_addr] <= 1'b1;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nib_cnt_q <= '0;
			rd_cnt_q <= '0;
			hit_found_q <= 1'b0;
			free_found_q <= 1'b0;
			op_q <= OP_GET;
			dev_q <= '0;
			blk_q <= '0;
			slot_q <= '0;
			bkt_q <= '0;
			way_q <= '0;
			hit_way_q <= '0;
			hit_rank_q <= '0;
			hit_cnt_q <= '0;
			hit_cval_q <= 1'b0;
			free_way_q <= '0;
			free_rank_q <= '0;
			old_rank_q <= '0;
			res_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						op_q <= op_t'(req.op);
						dev_q <= req.device;
						blk_q <= req.block_number;
						slot_q <= req.slot;
						res_q.slot <= req.slot;
						res_q.hit <= 1'b0;
						res_q.needs_read <= 1'b0;
						res_q.status <= STAT_OK;
						if (op_t'(req.op) == OP_GET) begin
							nib_cnt_q <= '0;
							bkt_q <= '0;
							state_q <= ST_HASH;
						end else if (slot_in_range) begin
							bkt_q <= slot_bkt(req.slot);
							way_q <= slot_way(req.slot);
							state_q <= ST_SLOT_UPD;
						end else begin
							// Out-of-range slot: echoed back with status ok.
							state_q <= ST_DONE;
						end
					end
				end
				ST_HASH: begin
					bkt_q <= mod_step(bkt_q, nib);
					nib_cnt_q <= nib_cnt_q + NIBC_W'(1);
					if (nib_cnt_q == NIBC_W'(NIB_N - 1)) begin
						rd_cnt_q <= '0;
						hit_found_q <= 1'b0;
						free_found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en)
						rd_cnt_q <= rd_cnt_q + WCNT_W'(1);
					if (rd_vld_s1) begin
						// Tag hit: the matching way of highest rank wins.
						if (rec_match && (!hit_found_q || (rd_rec.rank > hit_rank_q))) begin
							hit_found_q <= 1'b1;
							hit_way_q <= rd_way_s1;
							hit_rank_q <= rd_rec.rank;
							hit_cnt_q <= rd_rec.cnt;
							hit_cval_q <= rd_rec.cval;
						end
						// Victim: the idle way of lowest rank.
						if ((rd_rec.cnt == '0) &&
							(!free_found_q || (rd_rec.rank < free_rank_q))) begin
							free_found_q <= 1'b1;
							free_way_q <= rd_way_s1;
							free_rank_q <= rd_rec.rank;
						end
					end
					if (scan_last)
						state_q <= ST_GET_WR;
				end
				ST_GET_WR: begin
					if (hit_found_q) begin
						res_q.slot <= SLOT_W'(slot_addr(bkt_q, hit_way_q));
						res_q.hit <= 1'b1;
						if (hit_cnt_q == COUNT_MAX) begin
							res_q.needs_read <= 1'b0;
							res_q.status <= STAT_OVER;
						end else begin
							res_q.needs_read <= !hit_cval_q;
							res_q.status <= STAT_OK;
						end
					end else if (free_found_q) begin
						res_q.slot <= SLOT_W'(slot_addr(bkt_q, free_way_q));
						res_q.hit <= 1'b0;
						res_q.needs_read <= 1'b1;
						res_q.status <= STAT_OK;
					end else begin
						res_q.slot <= '0;
						res_q.hit <= 1'b0;
						res_q.needs_read <= 1'b0;
						res_q.status <= STAT_NOFREE;
					end
					state_q <= ST_DONE;
				end
				ST_SLOT_UPD: begin
					if (op_q == OP_PIN) begin
						if (rd_rec.cnt == COUNT_MAX)
							res_q.status <= STAT_OVER;
						state_q <= ST_DONE;
					end else if (rd_rec.cnt == '0) begin
						res_q.status <= STAT_UNDER;
						state_q <= ST_DONE;
					end else if ((op_q == OP_RELEASE) && (rd_rec.cnt == CNT_W'(1))) begin
						// Count reaches zero: the slot becomes most recent.
						old_rank_q <= rd_rec.rank;
						rd_cnt_q <= '0;
						state_q <= ST_SWEEP;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SWEEP: begin
					if (rd_en)
						rd_cnt_q <= rd_cnt_q + WCNT_W'(1);
					if (scan_last)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
				rsp_q <= res_q;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.result_slot = rsp_q.slot;
	assign rsp.hit = rsp_q.hit;
	assign rsp.needs_read = rsp_q.needs_read;
	assign rsp.status = rsp_q.status;

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the hashed LRU block cache directory.
//
// A queue of requests is built at time zero. While it is built, a private
// copy of the directory tracks which slots hold references, so that most
// releases, pins and unpins aim at slots that are really in use. A second
// copy of the directory sits beside the block. It is advanced once per
// accepted request transaction, and each prediction waits in a queue until
// the matching response transaction arrives.
module tb;
	import hlbcd_pkg::*;

	// Which copy of the directory a call works on.
	localparam int STIM_VIEW = 0;
	localparam int DUT_VIEW  = 1;

	localparam int RANDOM_ITEMS  = 370;
	localparam int QUIET_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int PHASE_ITEMS   = 64;

	typedef struct packed {
		op_t               op;
		logic [DEV_W-1:0]  device;
		logic [BLK_W-1:0]  block_number;
		logic [SLOT_W-1:0] slot;
	} request_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              hit;
		logic              needs_read;
		status_t           status;
	} outcome_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	hlbcd_req_if req_ch ();
	hlbcd_rsp_if rsp_ch ();

	hashed_lru_block_cache_directory DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Everything the bench drives lives in registers of its own that start at a
	// known value, so the block never sees an unknown input.
	logic     drv_valid = 1'b0;
	request_t drv_item  = '0;
	logic     rsp_ready = 1'b0;

	assign req_ch.valid        = drv_valid;
	assign req_ch.op           = drv_item.op;
	assign req_ch.device       = drv_item.device;
	assign req_ch.block_number = drv_item.block_number;
	assign req_ch.slot         = drv_item.slot;
	assign rsp_ch.ready        = rsp_ready;

	// Two copies of the directory state: one for planning, one for checking.
	logic [DEV_W-1:0]  tag_dev   [2][TOTAL_SLOTS];
	logic [BLK_W-1:0]  tag_blk   [2][TOTAL_SLOTS];
	logic              filled    [2][TOTAL_SLOTS];
	logic [CNT_W-1:0]  ref_cnt   [2][TOTAL_SLOTS];
	logic [RANK_W-1:0] recency   [2][TOTAL_SLOTS];

	request_t pending_requests [$];
	outcome_t expected_results [$];
	outcome_t next_expected;
	outcome_t predicted;

	int unsigned requests_planned  = 0;
	int unsigned requests_accepted = 0;
	int unsigned results_checked   = 0;
	int unsigned mismatches        = 0;
	int unsigned quiet_cycles      = 0;
	int unsigned n_hit = 0, n_miss = 0, n_nofree = 0, n_over = 0, n_under = 0;

	// Idle pattern changes every PHASE_ITEMS accepted requests: no idling, a
	// mostly idle sender, a mostly stalling receiver, then light idling on both.
	int unsigned idle_phase;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	assign idle_phase     = (requests_accepted / PHASE_ITEMS) % 4;
	assign send_idle_pct  = (idle_phase == 1) ? 65 : (idle_phase == 3) ? 6 : 0;
	assign recv_stall_pct = (idle_phase == 2) ? 65 : (idle_phase == 3) ? 6 : 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Reset is applied once, from time zero, and released on a clock edge.
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// After reset every tag reads as device 0, block 0, nothing is valid or
	// referenced, and each way ranks by its own index (way 0 least recent).
	function automatic void clear_directory(input int v);
		int s;
		for (s = 0; s < TOTAL_SLOTS; s++) begin
			tag_dev[v][s] = '0;
			tag_blk[v][s] = '0;
			filled[v][s]  = 1'b0;
			ref_cnt[v][s] = '0;
			recency[v][s] = RANK_W'(s % WAYS);
		end
	endfunction

	// Applies one request to a copy of the directory and returns the response
	// that it must produce.
	function automatic outcome_t serve_request(input int v, input request_t r);
		outcome_t o;
		int base;
		int found;
		int s;
		int w;
		o.slot       = r.slot;
		o.hit        = 1'b0;
		o.needs_read = 1'b0;
		o.status     = STAT_OK;
		if (r.op == OP_GET) begin
			base  = int'(r.block_number % 32'(NUM_BUCKETS)) * WAYS;
			found = -1;
			// Several ways may carry the same tag (all of them do after reset);
			// the most recent of them wins.
			for (w = 0; w < WAYS; w++) begin
				s = base + w;
				if (tag_dev[v][s] == r.device && tag_blk[v][s] == r.block_number &&
						(found < 0 || recency[v][s] > recency[v][found])) begin
					found = s;
				end
			end
			if (found >= 0) begin
				o.slot = SLOT_W'(found);
				o.hit  = 1'b1;
				if (ref_cnt[v][found] == COUNT_MAX) begin
					o.status = STAT_OVER;
				end else begin
					ref_cnt[v][found]++;
					o.needs_read     = ~filled[v][found];
					filled[v][found] = 1'b1;
				end
				return o;
			end
			// Miss: recycle the least recent way that nobody references.
			for (w = 0; w < WAYS; w++) begin
				s = base + w;
				if (ref_cnt[v][s] == '0 &&
						(found < 0 || recency[v][s] < recency[v][found])) begin
					found = s;
				end
			end
			if (found < 0) begin
				o.slot   = '0;
				o.status = STAT_NOFREE;
				return o;
			end
			tag_dev[v][found] = r.device;
			tag_blk[v][found] = r.block_number;
			ref_cnt[v][found] = CNT_W'(1);
			filled[v][found]  = 1'b1;
			o.slot            = SLOT_W'(found);
			o.needs_read      = 1'b1;
			return o;
		end
		// Slot numbers past the last buffer are echoed and otherwise ignored.
		if (r.slot >= TOTAL_SLOTS) begin
			return o;
		end
		s = int'(r.slot);
		if (r.op == OP_PIN) begin
			if (ref_cnt[v][s] == COUNT_MAX) begin
				o.status = STAT_OVER;
			end else begin
				ref_cnt[v][s]++;
			end
			return o;
		end
		if (ref_cnt[v][s] == '0) begin
			o.status = STAT_UNDER;
			return o;
		end
		ref_cnt[v][s]--;
		// A release that frees the buffer makes it the most recent way of its
		// bucket; the ways that ranked above it each move down one place.
		if (r.op == OP_RELEASE && ref_cnt[v][s] == '0) begin
			base = (s / WAYS) * WAYS;
			for (w = 0; w < WAYS; w++) begin
				if (recency[v][base + w] > recency[v][s]) begin
					recency[v][base + w]--;
				end
			end
			recency[v][s] = RANK_W'(WAYS - 1);
		end
		return o;
	endfunction

	// Appends one request to the stimulus and advances the planning copy, so
	// that the plan can see which slots are referenced.
	function automatic outcome_t queue_request(input op_t op, input logic [DEV_W-1:0] dev,
			input logic [BLK_W-1:0] blk, input logic [SLOT_W-1:0] slot);
		request_t r;
		r.op           = op;
		r.device       = dev;
		r.block_number = blk;
		r.slot         = slot;
		pending_requests.push_back(r);
		return serve_request(STIM_VIEW, r);
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatches++;
	endtask

	// Request driver. A new transaction is presented once the previous one has
	// been taken, unless the sender decides to stay idle for this cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else begin
			if (drv_valid && req_ch.ready) begin
				predicted = serve_request(DUT_VIEW, drv_item);
				expected_results.push_back(predicted);
				requests_accepted++;
				case (predicted.status)
					STAT_NOFREE: n_nofree++;
					STAT_OVER:   n_over++;
					STAT_UNDER:  n_under++;
					default: begin
						if (drv_item.op == OP_GET && predicted.hit) begin
							n_hit++;
						end else if (drv_item.op == OP_GET) begin
							n_miss++;
						end
					end
				endcase
			end
			if (!drv_valid || req_ch.ready) begin
				if (pending_requests.size() != 0 &&
						$urandom_range(99) >= send_idle_pct) begin
					drv_valid <= 1'b1;
					drv_item  <= pending_requests.pop_front();
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor. Every response transaction is matched against the
	// oldest outstanding prediction; the ready line stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_checked++;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("response %0d arrived with no request outstanding",
						results_checked));
				end else begin
					next_expected = expected_results.pop_front();
					if (rsp_ch.result_slot !== next_expected.slot ||
							rsp_ch.hit !== next_expected.hit ||
							rsp_ch.needs_read !== next_expected.needs_read ||
							rsp_ch.status !== next_expected.status) begin
						report_mismatch($sformatf(
							"response %0d: slot %0d hit %b read %b status %0d, want %0d %b %b %0d",
							results_checked, rsp_ch.result_slot, rsp_ch.hit,
							rsp_ch.needs_read, rsp_ch.status, next_expected.slot,
							next_expected.hit, next_expected.needs_read, next_expected.status));
					end
				end
			end
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog: a long run of cycles in which neither channel moves anything
	// means the block has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
					QUIET_LIMIT, expected_results.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		outcome_t o;
		int n;
		int s;
		int roll;
		int bkt;
		int held [$];
		logic [DEV_W-1:0]  dev;
		logic [BLK_W-1:0]  blk;
		logic [SLOT_W-1:0] slot;

		clear_directory(STIM_VIEW);
		clear_directory(DUT_VIEW);

		// Directed part. Bucket 0 starts with four ways tagged device 0, block 0,
		// so the first get hits without a prior miss and still needs a read.
		void'(queue_request(OP_GET, 8'h00, 32'h0000_0000, 6'd0));
		void'(queue_request(OP_GET, 8'h00, 32'h0000_0000, 6'd0));
		void'(queue_request(OP_RELEASE, 8'h00, 32'h0, 6'd3));
		void'(queue_request(OP_RELEASE, 8'h00, 32'h0, 6'd3));
		// A third release of the same slot would go below zero and is refused.
		void'(queue_request(OP_RELEASE, 8'h00, 32'h0, 6'd3));
		void'(queue_request(OP_GET, 8'hFF, 32'hFFFF_FFFF, 6'd0));
		void'(queue_request(OP_GET, 8'h00, 32'h0000_000D, 6'd0));
		// Fill bucket 1 with referenced blocks, then ask for a fifth one.
		void'(queue_request(OP_GET, 8'h01, 32'd1, 6'd0));
		void'(queue_request(OP_GET, 8'h01, 32'd14, 6'd0));
		void'(queue_request(OP_GET, 8'h01, 32'd27, 6'd0));
		void'(queue_request(OP_GET, 8'h01, 32'd40, 6'd0));
		void'(queue_request(OP_GET, 8'h01, 32'd53, 6'd0));
		// Freeing one way lets the retried get recycle it.
		void'(queue_request(OP_RELEASE, 8'h00, 32'h0, 6'd5));
		void'(queue_request(OP_GET, 8'h01, 32'd53, 6'd0));
		void'(queue_request(OP_GET, 8'h01, 32'd1, 6'd0));
		// Pin and unpin leave recency alone, even when the count reaches zero.
		void'(queue_request(OP_PIN, 8'h00, 32'h0, 6'd6));
		void'(queue_request(OP_UNPIN, 8'h00, 32'h0, 6'd6));
		void'(queue_request(OP_UNPIN, 8'h00, 32'h0, 6'd6));
		void'(queue_request(OP_UNPIN, 8'h00, 32'h0, 6'd6));
		// Slots past the last buffer.
		void'(queue_request(OP_PIN, 8'h00, 32'h0, 6'd63));
		void'(queue_request(OP_RELEASE, 8'h00, 32'h0, 6'd52));
		void'(queue_request(OP_UNPIN, 8'h00, 32'h0, 6'd55));
		void'(queue_request(OP_GET, 8'hA5, 32'h5A5A_5A5A, 6'd0));
		void'(queue_request(OP_GET, 8'h5A, 32'hA5A5_A5A5, 6'd0));
		void'(queue_request(OP_RELEASE, 8'h00, 32'h0, 6'd4));

		// Random part. Gets mostly hit a few busy buckets with a small set of
		// tags, so hits, recycling and full buckets all occur often; releases,
		// pins and unpins mostly aim at referenced slots.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) begin
				// Drive one buffer to the count ceiling, push past it with a pin
				// and a get, then unpin it once and release it the rest of the way to free.
				o = queue_request(OP_GET, 8'h7E, 32'd7, 6'($urandom));
				s = (o.status == STAT_OK) ? int'(o.slot) : 7 * WAYS;
				while (ref_cnt[STIM_VIEW][s] != COUNT_MAX) begin
					void'(queue_request(OP_PIN, 8'($urandom), $urandom, SLOT_W'(s)));
				end
				void'(queue_request(OP_PIN, 8'($urandom), $urandom, SLOT_W'(s)));
				void'(queue_request(OP_GET, 8'h7E, 32'd7, 6'($urandom)));
				void'(queue_request(OP_UNPIN, 8'($urandom), $urandom, SLOT_W'(s)));
				while (ref_cnt[STIM_VIEW][s] != '0) begin
					void'(queue_request(OP_RELEASE, 8'($urandom), $urandom, SLOT_W'(s)));
				end
			end
			held.delete();
			for (s = 0; s < TOTAL_SLOTS; s++) begin
				if (ref_cnt[STIM_VIEW][s] != '0) begin
					held.push_back(s);
				end
			end
			roll = $urandom_range(99);
			bkt  = ($urandom_range(3) == 0) ? $urandom_range(NUM_BUCKETS - 1)
				: 3 * $urandom_range(2) + 2;
			dev  = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(1));
			blk  = 32'(bkt + NUM_BUCKETS * $urandom_range(5));
			slot = (held.size() != 0) ? SLOT_W'(held[$urandom_range(held.size() - 1)])
				: SLOT_W'($urandom_range(63));
			if (roll < 35 || (held.size() == 0 && roll < 82)) begin
				void'(queue_request(OP_GET, dev, blk, 6'($urandom)));
			end else if (roll < 70) begin
				void'(queue_request(OP_RELEASE, 8'($urandom), $urandom, slot));
			end else if (roll < 75) begin
				void'(queue_request(OP_PIN, 8'($urandom), $urandom, slot));
			end else if (roll < 82) begin
				void'(queue_request(OP_UNPIN, 8'($urandom), $urandom, slot));
			end else if (roll < 88) begin
				void'(queue_request(OP_GET, 8'($urandom), $urandom, 6'($urandom)));
			end else if (roll < 94) begin
				void'(queue_request($urandom_range(1) ? OP_RELEASE : OP_UNPIN,
					8'($urandom), $urandom, 6'($urandom_range(63))));
			end else begin
				void'(queue_request(OP_PIN, 8'($urandom), $urandom, 6'($urandom_range(63))));
			end
		end
		requests_planned = pending_requests.size();

		// Wait for every request to be taken and every response to come back,
		// then leave room for anything the block might still emit.
		while (requests_accepted < requests_planned || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests and %0d responses: %0d hits, %0d misses,",
			requests_accepted, results_checked, n_hit, n_miss);
		$display("%0d full-bucket refusals, %0d count overflows, %0d count underflows.",
			n_nofree, n_over, n_under);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/hlbcd_pkg.sv
hw/rtl/hlbcd_req_if.sv
hw/rtl/hlbcd_rsp_if.sv
hw/rtl/hashed_lru_block_cache_directory.sv
tb/tb.sv
